FILE: rtl/sm3_hash_engine_top_macros.svh
// assertion macros for the sm3 hash engine
`ifndef SM3_HASH_ENGINE_TOP_MACROS_SVH
`define SM3_HASH_ENGINE_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SM3_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication outside reset
`define SM3_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

FILE: rtl/sm3_pkg.sv
// shared types and constants of the sm3 hash engine
package sm3_pkg;
    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [255:0] SM3_IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7,
        32'hDA8A0600, 32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    // datapath commands from the controller
    typedef struct packed {
        logic       load_byte;   // write byte at position into block
        logic [7:0] byte_val;
        logic [5:0] byte_pos;
        logic       count_byte;  // add 8 to bit count
        logic       clear_block; // zero block words
        logic       put_len;     // write bit count into words 14 and 15
        logic       start_blk;   // load working regs from chaining value
        logic       round_en;    // run one round
        logic [5:0] round_idx;
        logic       finish_blk;  // xor working regs into chaining value
        logic       reset_msg;   // restore iv and bit count
    } t_cmd;

    typedef struct packed {
        logic pad_spill;         // pad byte lands at 56 or later, length needs a new block
    } t_status;

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
    endfunction
endpackage

FILE: rtl/sm3_datapath.sv
// sm3 block buffer, message expansion window and round datapath
module sm3_datapath import sm3_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_status       o_status,
    output logic [255:0]  o_digest
);
    logic [31:0] r_blk [16];
    logic [31:0] r_win [16];
    logic [31:0] r_wk  [8];
    logic [255:0] r_cv;
    logic [63:0] r_bits;
    logic [31:0] n_w;
    logic [31:0] wj, wj4, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    logic [3:0]  widx;
    logic [1:0]  lane;

    assign widx = i_cmd.byte_pos[5:2];
    assign lane = i_cmd.byte_pos[1:0];

    // window holds w[j..j+15]; new word w[j+16]
    assign n_w = perm1(r_win[0] ^ r_win[7] ^ rol32(r_win[13], 5'd15))
                 ^ rol32(r_win[3], 5'd7) ^ r_win[10];
    assign wj  = r_win[0];
    assign wj4 = r_win[4];
    assign tj  = (i_cmd.round_idx <= 6'd15) ? T_LOW : T_HIGH;
    assign a12 = rol32(r_wk[0], 5'd12);
    assign ss1 = rol32(a12 + r_wk[4] + rol32(tj, i_cmd.round_idx[4:0]), 5'd7);
    assign ss2 = ss1 ^ a12;
    always_comb begin
        if (i_cmd.round_idx <= 6'd15) begin
            ff = r_wk[0] ^ r_wk[1] ^ r_wk[2];
            gg = r_wk[4] ^ r_wk[5] ^ r_wk[6];
        end else begin
            ff = (r_wk[0] & r_wk[1]) | (r_wk[0] & r_wk[2]) | (r_wk[1] & r_wk[2]);
            gg = (r_wk[4] & r_wk[5]) | (~r_wk[4] & r_wk[6]);
        end
    end
    assign tt1 = ff + r_wk[3] + ss2 + (wj ^ wj4);
    assign tt2 = gg + r_wk[7] + ss1 + wj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_block) begin
            for (int k = 0; k < 16; k++) r_blk[k] <= '0;
        end else if (i_cmd.load_byte) begin
            case (lane)
                2'd0: r_blk[widx][31:24] <= i_cmd.byte_val;
                2'd1: r_blk[widx][23:16] <= i_cmd.byte_val;
                2'd2: r_blk[widx][15:8]  <= i_cmd.byte_val;
                default: r_blk[widx][7:0] <= i_cmd.byte_val;
            endcase
        end else if (i_cmd.put_len) begin
            r_blk[14] <= r_bits[63:32];
            r_blk[15] <= r_bits[31:0];
        end
        if (i_cmd.start_blk) begin
            for (int k = 0; k < 16; k++) r_win[k] <= r_blk[k];
            for (int k = 0; k < 8; k++) r_wk[k] <= r_cv[255-32*k -: 32];
        end else if (i_cmd.round_en) begin
            for (int k = 0; k < 15; k++) r_win[k] <= r_win[k+1];
            r_win[15] <= n_w;
            r_wk[3] <= r_wk[2];
            r_wk[2] <= rol32(r_wk[1], 5'd9);
            r_wk[1] <= r_wk[0];
            r_wk[0] <= tt1;
            r_wk[7] <= r_wk[6];
            r_wk[6] <= rol32(r_wk[5], 5'd19);
            r_wk[5] <= r_wk[4];
            r_wk[4] <= perm0(tt2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reset_msg) begin
            r_cv   <= SM3_IV;
            r_bits <= '0;
        end else begin
            if (i_cmd.count_byte) r_bits <= r_bits + 64'd8;
            if (i_cmd.finish_blk) begin
                r_cv <= r_cv ^ {r_wk[0], r_wk[1], r_wk[2], r_wk[3],
                                r_wk[4], r_wk[5], r_wk[6], r_wk[7]};
            end
        end
    end

    // bytes in block is bit count / 8 mod 64; 56 and up leaves no room for the length
    assign o_status.pad_spill = (r_bits[8:6] == 3'b111);
    assign o_digest = r_cv;
endmodule

FILE: rtl/sm3_ctrl.sv
// sm3 sequencer: byte intake, padding, rounds and digest output
module sm3_ctrl import sm3_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_byte,
    input  logic         i_present,
    input  logic         i_end,
    output t_cmd         o_cmd,
    input  t_status      i_status,
    input  logic [255:0] i_digest,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [31:0]  o_word,
    output logic [2:0]   o_index,
    output logic         o_last
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [5:0] r_pos, n_pos;
    logic [5:0] r_rnd, n_rnd;
    logic       r_end, n_end;    // message ends after current block
    logic       r_lenblk, n_lenblk; // current block is a padded end block: the final one or a spill block before it
    logic [2:0] r_oidx, n_oidx;
    logic       r_ov, n_ov;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_widx, n_widx;
    logic [255:0] sh;

    assign o_ready = (r_state == ST_IDLE);
    assign sh = i_digest << {r_oidx, 5'd0};

    always_comb begin
        n_state = r_state; n_pos = r_pos; n_rnd = r_rnd; n_end = r_end;
        n_lenblk = r_lenblk; n_oidx = r_oidx; n_ov = r_ov;
        n_word = r_word; n_widx = r_widx;
        o_cmd = '0;
        o_cmd.round_idx = r_rnd;
        o_cmd.byte_pos = r_pos;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_end = i_end;
                    if (i_present) begin
                        o_cmd.load_byte = 1'b1;
                        o_cmd.byte_val = i_byte;
                        o_cmd.count_byte = 1'b1;
                        n_pos = r_pos + 6'd1;
                        if (r_pos == 6'd63) begin
                            n_lenblk = 1'b0;
                            n_state = ST_START;
                        end else if (i_end) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_end) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // pad byte then zeros to end of block, one byte a cycle
                o_cmd.load_byte = 1'b1;
                o_cmd.byte_val = r_end ? PAD_BYTE : 8'h00;
                n_end = 1'b0;
                n_pos = r_pos + 6'd1;
                if (r_pos == 6'd63) begin
                    n_pos = '0;
                    // no room for the length: run this block as a spill block first
                    n_end = i_status.pad_spill;
                    n_lenblk = 1'b1;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (r_lenblk && !r_end) begin
                    o_cmd.put_len = 1'b1;
                end
                n_state = ST_ROUND;
                n_rnd = '0;
            end
            ST_ROUND: begin
                if (r_lenblk && !r_end && r_rnd == 6'd0 && r_oidx == 3'd7) begin
                    o_cmd.start_blk = 1'b1;
                    n_oidx = '0;
                end else begin
                    o_cmd.round_en = 1'b1;
                    n_rnd = r_rnd + 6'd1;
                    if (r_rnd == 6'd63) n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish_blk = 1'b1;
                o_cmd.clear_block = 1'b1;
                if (r_lenblk && r_end) begin
                    // spill block done, length goes in a fresh block
                    n_end = 1'b0;
                    n_state = ST_START;
                end else if (r_lenblk) begin
                    n_oidx = '0;
                    n_state = ST_OUT;
                end else if (r_end) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1;
                    n_word = sh[255:224];
                    n_widx = r_oidx;
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_state = ST_IDLE;
                        o_cmd.reset_msg = 1'b1;
                        n_pos = '0;
                        n_lenblk = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // start of block: load working registers once before rounds
        if (r_state == ST_START && n_state == ST_ROUND) o_cmd.start_blk = !o_cmd.put_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_pos <= '0; r_rnd <= '0; r_end <= 1'b0;
            r_lenblk <= 1'b0; r_oidx <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_pos <= n_pos; r_rnd <= n_rnd; r_end <= n_end;
            r_lenblk <= n_lenblk; r_ov <= n_ov;
            r_oidx <= (r_state == ST_START && o_cmd.put_len) ? 3'd7 : n_oidx;
        end
    end
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_widx <= n_widx;
    end

    assign o_out_valid = r_ov;
    assign o_word  = r_word;
    assign o_index = r_widx;
    assign o_last  = (r_widx == 3'd7);
endmodule

FILE: rtl/sm3_hash_engine_top.sv
// sm3 hash engine top level: stream ports, controller and datapath
// usage:
//   slave channel takes one item per handshake: a message byte with a
//   present flag in tuser and the end-of-message flag in tlast
//   a full 64-byte block runs in the round unit as load, 64 rounds and
//   fold; the round unit does one compression round per cycle
//   after a byte that neither fills a block nor ends the message, s_axis_tready stays high
//   end of message pads one byte per cycle up to the block end, runs the
//   final block (and a spill block when fewer than nine bytes remained)
//   then emits eight digest words on the master channel, word 0 first
//   while a block or the digest is in progress s_axis_tready is low
//   a stalled master side holds its item; the engine waits per word
//   reset is synchronous active low; it restores the iv and clears counts
//   results out: tdata digest word, tuser word index, tlast on word 7
`include "sm3_hash_engine_top_macros.svh"
module sm3_hash_engine_top import sm3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] byte_present
    input  logic        s_axis_tlast,  // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,  // [2:0] word_index
    output logic        m_axis_tlast   // last_word
);
    t_cmd         cmd;
    t_status      status;
    logic [255:0] digest;

    sm3_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_present(s_axis_tuser), .i_end(s_axis_tlast),
        .o_cmd(cmd), .i_status(status), .i_digest(digest),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_word(m_axis_tdata), .o_index(m_axis_tuser), .o_last(m_axis_tlast)
    );

    sm3_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status), .o_digest(digest)
    );

    // no input is taken while a digest word other than word 7 waits
    `SM3_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready && m_axis_tuser != 3'd7, !s_axis_tready, "input accepted during digest")
    // last flag only on word seven
    `SM3_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == 3'd7, "last without index 7")
    // rounds never overlap byte loads or block starts
    `SM3_ASSERT_IMPL(a_cmd_excl, i_clk, i_rst_n, cmd.round_en, !cmd.load_byte && !cmd.start_blk, "command overlap")
endmodule
